/* hw/rtl/chs_pkg.sv */
// Shared types and codes for the chained hash set.
// No dependencies; used by chained_hash_set.
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

  localparam int VALUE_W  = 16;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // request kinds; the spare code acts as a search
  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_SEARCH = 2'd2;

  localparam status_t ST_ADDED     = 3'd0;
  localparam status_t ST_DUPLICATE = 3'd1;
  localparam status_t ST_REMOVED   = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_FOUND     = 3'd4;
  localparam status_t ST_FULL      = 3'd5;

endpackage

`default_nettype wire

/* hw/rtl/chained_hash_set.sv */
// Chained hash set of signed 16-bit keys: add, delete and search requests.
// Depends on chs_pkg (types, request and status codes).
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high and busy is low. Its one result
// appears on status and found, marked by done for a single cycle; the
// receiver must take it then. The bucket is (|value|^2) mod NUM_BUCKETS,
// found by one shared remainder unit (reciprocal multiply, then subtract)
// that runs twice: on |value|, then on the square of that remainder, with
// a squaring step between. The bucket's slots are then read from one
// memory port, one slot per cycle, and the next request can start in the
// cycle done is shown. After reset the block sweeps the entry memory clear,
// with busy high, before it takes the first request.
module chained_hash_set #(
  parameter int NUM_BUCKETS  = 7,
  parameter int BUCKET_SLOTS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire chs_pkg::op_t                 op,
  input  wire logic signed [chs_pkg::VALUE_W-1:0] value,
  output logic                              done,
  output chs_pkg::status_t                  status,
  output logic                              found
);

  localparam int VW    = chs_pkg::VALUE_W;
  localparam int TOTAL = NUM_BUCKETS * BUCKET_SLOTS;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int SW    = $clog2(BUCKET_SLOTS + 1);
  localparam int RW    = VW + 2;
  localparam int SHIFT = VW + BW;

  // ceil(2^SHIFT / N): exact quotient for every operand below 2^VW
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);

  localparam logic [RW-1:0] RECIP     = RW'(RECIP_L);
  localparam logic [VW-1:0] NB_V      = VW'(NUM_BUCKETS);
  localparam logic [AW-1:0] SLOTS_A   = AW'(BUCKET_SLOTS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);
  localparam logic [SW-1:0] SLOTS_S   = SW'(BUCKET_SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(BUCKET_SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MUL, S_REM, S_SQUARE, S_BASE, S_SCAN, S_UPDATE
  } state_t;

  state_t            state;
  chs_pkg::op_t      req_op;
  logic [VW-1:0]     req_value;
  logic [VW-1:0]     sh;          // operand of the remainder unit
  logic [VW-1:0]     quo;
  logic              sq_pass;
  logic [BW-1:0]     red;         // remainder, later the bucket
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     chk_addr;
  logic              pend;
  logic [SW-1:0]     iss_cnt;
  logic [SW-1:0]     chk_cnt;
  logic              hit;
  logic [AW-1:0]     hit_addr;
  logic              has_free;
  logic [AW-1:0]     free_addr;

  // memory: {valid, value}
  logic [VW:0]       mem [TOTAL];
  logic [VW:0]       mem_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [VW:0]       mem_wdata;

  logic              accept;
  logic [VW-1:0]     mag;
  logic [VW+RW-1:0]  prod;
  logic [2*BW-1:0]   sq;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign mag    = value[VW-1] ? (~value + VW'(1)) : value;

  // shared remainder unit: quotient by reciprocal multiply
  assign prod = (VW+RW)'(sh) * (VW+RW)'(RECIP);

  assign sq = (2*BW)'(red) * (2*BW)'(red);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_UPDATE: begin
        if (req_op == chs_pkg::OP_ADD && !hit && has_free) begin
          mem_we    = 1'b1;
          mem_waddr = free_addr;
          mem_wdata = {1'b1, req_value};
        end else if (req_op == chs_pkg::OP_DELETE && hit) begin
          mem_we    = 1'b1;
          mem_waddr = hit_addr;
          mem_wdata = {1'b0, req_value};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      pend     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_op    <= op;
            req_value <= value;
            sh        <= mag;
            sq_pass   <= 1'b0;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          quo   <= VW'(prod >> SHIFT);
          state <= S_REM;
        end
        S_REM: begin
          red <= BW'(sh - VW'(quo * NB_V));
          if (sq_pass) begin
            state <= S_BASE;
          end else begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          sh      <= VW'(sq);
          sq_pass <= 1'b1;
          state   <= S_MUL;
        end
        S_BASE: begin
          rd_addr  <= AW'(AW'(red) * SLOTS_A);
          iss_cnt  <= '0;
          chk_cnt  <= '0;
          pend     <= 1'b0;
          hit      <= 1'b0;
          has_free <= 1'b0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          // reads issue one per cycle; each is checked the cycle after
          if (iss_cnt != SLOTS_S) begin
            pend     <= 1'b1;
            chk_addr <= rd_addr;
            rd_addr  <= rd_addr + 1'b1;
            iss_cnt  <= iss_cnt + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (mem_q[VW]) begin
              if (!hit && mem_q[VW-1:0] == req_value) begin
                hit      <= 1'b1;
                hit_addr <= chk_addr;
              end
            end else if (!has_free) begin
              has_free  <= 1'b1;
              free_addr <= chk_addr;
            end
            chk_cnt <= chk_cnt + 1'b1;
            if (chk_cnt == LAST_SLOT) begin
              state <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          done  <= 1'b1;
          found <= hit;
          case (req_op)
            chs_pkg::OP_ADD: begin
              if (hit) begin
                status <= chs_pkg::ST_DUPLICATE;
              end else if (!has_free) begin
                status <= chs_pkg::ST_FULL;
              end else begin
                status <= chs_pkg::ST_ADDED;
              end
            end
            chs_pkg::OP_DELETE: begin
              status <= hit ? chs_pkg::ST_REMOVED : chs_pkg::ST_NOT_FOUND;
            end
            default: begin
              status <= hit ? chs_pkg::ST_FOUND : chs_pkg::ST_NOT_FOUND;
            end
          endcase
          pend  <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("busy not raised after a request");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (found == (status == chs_pkg::ST_DUPLICATE ||
                        status == chs_pkg::ST_REMOVED ||
                        status == chs_pkg::ST_FOUND)))
    else $error("found disagrees with status");

endmodule

`default_nettype wire
